[hw/rtl/dadsr_pkg.sv]
`default_nettype none
package dadsr_pkg;

	localparam int CMD_W     = 2;
	localparam int TRK_W     = 4;
	localparam int NOTE_W    = 7;
	localparam int LVL_W     = 25;
	localparam int STG_W     = 3;
	localparam int DLY_W     = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 25;

	localparam logic [LVL_W-1:0]  ONE_Q24       = 25'd16777216;
	localparam logic [LVL_W-1:0]  ATTACK_DONE   = 25'd16775539;
	localparam logic [LVL_W-1:0]  DECAY_TOL     = 25'd8388;
	localparam logic [LVL_W-1:0]  RELEASE_FLOOR = 25'd1677;
	localparam logic [NOTE_W-1:0] REF_NOTE      = 7'd60;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2,
		CMD_ALL_OFF  = 2'd3
	} cmd_t;

	typedef enum logic [STG_W-1:0] {
		ST_IDLE    = 3'd0,
		ST_DELAY   = 3'd1,
		ST_ATTACK  = 3'd2,
		ST_DECAY   = 3'd3,
		ST_SUSTAIN = 3'd4,
		ST_RELEASE = 3'd5
	} stage_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK_STEP  = 3'd0,
		CFG_DECAY_STEP   = 3'd1,
		CFG_RELEASE_STEP = 3'd2,
		CFG_SUSTAIN      = 3'd3,
		CFG_DELAY        = 3'd4,
		CFG_RETRIG_ZERO  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		stage_t              stage;
		logic [LVL_W-1:0]    level;
		logic [DLY_W-1:0]    dly;
		logic                held;
		logic [NOTE_W-1:0]   hnote;
	} trk_state_t;

	localparam trk_state_t TRK_RESET = '{
		stage: ST_IDLE,
		level: '0,
		dly:   '0,
		held:  1'b0,
		hnote: REF_NOTE
	};

endpackage
`default_nettype wire

[hw/rtl/delayed_adsr_envelope_top.sv]
// Per-track linear envelope generator (delay, attack, decay, sustain, release).
// One transaction is accepted every clock cycle when the result side keeps up;
// each transaction passes the input stage and the result register: the accepting
// edge also reads the track's state from a RAM (one entry per track), and the
// input stage then computes the next state in one pass, writes it back and
// registers the result once the result side can take it.
// Back-to-back transactions on the same track are forwarded around the RAM.
// Per-track valid bits cleared by reset make every track start idle at level
// zero with no clearing pass. The user writes settings through cfg_we/cfg_idx/
// cfg_wdata only with no transaction in flight; the block does not enforce it.
`default_nettype none
module delayed_adsr_envelope_top #(
	parameter int TRACKS = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [dadsr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire  [dadsr_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [dadsr_pkg::CMD_W-1:0]   cmd,
	input  wire  [dadsr_pkg::TRK_W-1:0]   track,
	input  wire  [dadsr_pkg::NOTE_W-1:0]  note,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [dadsr_pkg::LVL_W-1:0]   level,
	output logic [dadsr_pkg::STG_W-1:0]   stage
);

	import dadsr_pkg::*;

	localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int TW = (IW > TRK_W) ? IW : TRK_W;
	localparam int SW = $bits(trk_state_t);

	function automatic logic [LVL_W-1:0] move_toward(input logic [LVL_W-1:0] cur,
			input logic [LVL_W-1:0] tgt, input logic [LVL_W-1:0] step);
		logic [LVL_W:0]   sum;
		logic [LVL_W-1:0] diff;
		sum = {1'b0, cur} + {1'b0, step};
		diff = cur - tgt;
		if (cur < tgt) begin
			move_toward = (sum > {1'b0, tgt}) ? tgt : sum[LVL_W-1:0];
		end else if (diff <= step) begin
			move_toward = tgt;
		end else begin
			move_toward = cur - step;
		end
	endfunction

	// configuration
	logic [LVL_W-1:0] attack_step_q, decay_step_q, release_step_q, sustain_q;
	logic [DLY_W-1:0] delay_q;
	logic             retrig_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_step_q  <= 25'd34953;
			decay_step_q   <= 25'd3495;
			release_step_q <= 25'd3495;
			sustain_q      <= ONE_Q24;
			delay_q        <= '0;
			retrig_zero_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_ATTACK_STEP:  attack_step_q  <= cfg_wdata[LVL_W-1:0];
				CFG_DECAY_STEP:   decay_step_q   <= cfg_wdata[LVL_W-1:0];
				CFG_RELEASE_STEP: release_step_q <= cfg_wdata[LVL_W-1:0];
				CFG_SUSTAIN:      sustain_q      <= cfg_wdata[LVL_W-1:0];
				CFG_DELAY:        delay_q        <= cfg_wdata[DLY_W-1:0];
				CFG_RETRIG_ZERO:  retrig_zero_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input stage
	logic              v_s1, inr_s1, byp_s1;
	cmd_t              cmd_s1;
	logic [IW-1:0]     idx_s1;
	logic [NOTE_W-1:0] note_s1;
	trk_state_t        bypd_s1;

	logic              out_valid_q;
	logic [LVL_W-1:0]  level_q;
	logic [STG_W-1:0]  stage_q;
	logic [TRACKS-1:0] vld_q;

	logic              adv, accept, wr_en, in_range;
	logic [TW-1:0]     trk_ext;
	logic [IW-1:0]     in_idx;
	logic [SW-1:0]     rd_word;
	trk_state_t        cur, nxt;
	logic [LVL_W-1:0]  sus, lv, lvl_gap;
	logic [DLY_W-1:0]  dl;

	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign accept   = in_valid && in_ready;
	assign wr_en    = adv && inr_s1;
	assign trk_ext  = TW'(track);
	assign in_idx   = trk_ext[IW-1:0];
	assign in_range = 32'(track) < 32'(TRACKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(cmd);
			idx_s1  <= in_idx;
			note_s1 <= note;
			inr_s1  <= in_range;
			byp_s1  <= wr_en && (idx_s1 == in_idx);
			bypd_s1 <= nxt;
		end
	end

	dadsr_ram #(
		.WIDTH(SW),
		.DEPTH(TRACKS)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (nxt),
		.re    (accept),
		.raddr (in_idx),
		.rdata (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[idx_s1] <= 1'b1;
		end
	end

	// next track state
	always_comb begin
		if (byp_s1) begin
			cur = bypd_s1;
		end else if (vld_q[idx_s1]) begin
			cur = trk_state_t'(rd_word);
		end else begin
			cur = TRK_RESET;
		end
		sus     = (sustain_q > ONE_Q24) ? ONE_Q24 : sustain_q;
		nxt     = cur;
		lv      = '0;
		lvl_gap = '0;
		dl      = '0;
		case (cmd_s1)
			CMD_TICK: begin
				case (cur.stage)
					ST_DELAY: begin
						dl = (cur.dly != '0) ? cur.dly - 1'b1 : cur.dly;
						nxt.dly = dl;
						if (dl == '0) begin
							nxt.stage = ST_ATTACK;
						end
					end
					ST_ATTACK: begin
						lv = move_toward(cur.level, ONE_Q24, attack_step_q);
						if (lv >= ATTACK_DONE) begin
							lv = ONE_Q24;
							nxt.stage = ST_DECAY;
						end
						nxt.level = lv;
					end
					ST_DECAY: begin
						lv = move_toward(cur.level, sus, decay_step_q);
						lvl_gap = (lv >= sus) ? lv - sus : sus - lv;
						if (lvl_gap <= DECAY_TOL) begin
							lv = sus;
							nxt.stage = ST_SUSTAIN;
						end
						nxt.level = lv;
					end
					ST_SUSTAIN: begin
						nxt.level = sus;
					end
					ST_RELEASE: begin
						lv = move_toward(cur.level, '0, release_step_q);
						if (lv <= RELEASE_FLOOR) begin
							lv = '0;
							nxt.stage = ST_IDLE;
						end
						nxt.level = lv;
					end
					default: begin
						nxt.level = '0;
					end
				endcase
			end
			CMD_NOTE_ON: begin
				nxt.hnote = note_s1;
				nxt.held  = 1'b1;
				if (retrig_zero_q) begin
					nxt.level = '0;
				end
				nxt.dly   = delay_q;
				nxt.stage = (delay_q != '0) ? ST_DELAY : ST_ATTACK;
			end
			CMD_NOTE_OFF: begin
				if (cur.held && (cur.hnote == note_s1)) begin
					nxt.held  = 1'b0;
					nxt.stage = ST_RELEASE;
				end
			end
			default: begin
				nxt = TRK_RESET;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_q <= inr_s1 ? nxt.level : '0;
			stage_q <= inr_s1 ? nxt.stage : ST_IDLE;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign stage     = stage_q;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted transaction did not reach the input stage");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> level_q <= ONE_Q24)
		else $error("result level above full scale");

	a_stage_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> stage_q <= ST_RELEASE)
		else $error("result stage code out of range");

	a_no_write_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> v_s1 && $stable(idx_s1) && $stable(vld_q))
		else $error("state changed while the input stage was stalled");

endmodule
`default_nettype wire

[hw/rtl/dadsr_ram.sv]
`default_nettype none
module dadsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                    clk,
	input  wire                                    we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                       wdata,
	input  wire                                    re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[tb/delayed_adsr_envelope_top_test.sv]
`default_nettype none
module delayed_adsr_envelope_top_test;
	import dadsr_pkg::*;

	localparam int TRACKS_N    = 16;
	localparam int REG_COUNT   = 6;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 215;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 10;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [CFG_W-1:0] STEP_MAX = '1;
	localparam logic [DLY_W-1:0] DLY_MAX  = '1;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic [LVL_W-1:0] level;
		stage_t           stage;
	} env_result_t;

	class envelope_scoreboard;
		stage_t            trk_stage [TRACKS_N];
		logic [LVL_W-1:0]  trk_level [TRACKS_N];
		logic [DLY_W-1:0]  trk_wait  [TRACKS_N];
		logic              trk_held  [TRACKS_N];
		logic [NOTE_W-1:0] trk_note  [TRACKS_N];
		logic [LVL_W-1:0]  attack_step, decay_step, release_step, sustain_lvl;
		logic [DLY_W-1:0]  delay_len;
		logic              retrig_zero;
		env_result_t       expected_q [$];
		int                errors;
		int                checked;

		function new();
			attack_step  = 25'd34953;
			decay_step   = 25'd3495;
			release_step = 25'd3495;
			sustain_lvl  = ONE_Q24;
			delay_len    = '0;
			retrig_zero  = 1'b1;
			for (int t = 0; t < TRACKS_N; t++) begin
				trk_stage[t] = ST_IDLE;
				trk_level[t] = '0;
				trk_wait[t]  = '0;
				trk_held[t]  = 1'b0;
				trk_note[t]  = REF_NOTE;
			end
			errors  = 0;
			checked = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				CFG_ATTACK_STEP:  attack_step  = v;
				CFG_DECAY_STEP:   decay_step   = v;
				CFG_RELEASE_STEP: release_step = v;
				CFG_SUSTAIN:      sustain_lvl  = v;
				CFG_DELAY:        delay_len    = v[DLY_W-1:0];
				CFG_RETRIG_ZERO:  retrig_zero  = v[0];
				default: ;
			endcase
		endfunction

		function logic [LVL_W-1:0] approach(logic [LVL_W-1:0] cur, logic [LVL_W-1:0] tgt,
				logic [LVL_W-1:0] stp);
			logic [LVL_W:0] sum;
			if (cur < tgt) begin
				sum = {1'b0, cur} + {1'b0, stp};
				return (sum > {1'b0, tgt}) ? tgt : sum[LVL_W-1:0];
			end
			if (cur - tgt <= stp)
				return tgt;
			return cur - stp;
		endfunction

		function void advance(int t);
			logic [LVL_W-1:0] sus, v, diff;
			sus = (sustain_lvl > ONE_Q24) ? ONE_Q24 : sustain_lvl;
			case (trk_stage[t])
				ST_DELAY: begin
					if (trk_wait[t] != '0)
						trk_wait[t] = trk_wait[t] - 1'b1;
					if (trk_wait[t] == '0)
						trk_stage[t] = ST_ATTACK;
				end
				ST_ATTACK: begin
					v = approach(trk_level[t], ONE_Q24, attack_step);
					if (v >= ATTACK_DONE) begin
						v = ONE_Q24;
						trk_stage[t] = ST_DECAY;
					end
					trk_level[t] = v;
				end
				ST_DECAY: begin
					v = approach(trk_level[t], sus, decay_step);
					diff = (v >= sus) ? v - sus : sus - v;
					if (diff <= DECAY_TOL) begin
						v = sus;
						trk_stage[t] = ST_SUSTAIN;
					end
					trk_level[t] = v;
				end
				ST_SUSTAIN: trk_level[t] = sus;
				ST_RELEASE: begin
					v = approach(trk_level[t], '0, release_step);
					if (v <= RELEASE_FLOOR) begin
						v = '0;
						trk_stage[t] = ST_IDLE;
					end
					trk_level[t] = v;
				end
				default: trk_level[t] = '0;
			endcase
		endfunction

		function void note_input(cmd_t c, logic [TRK_W-1:0] trk, logic [NOTE_W-1:0] n);
			env_result_t r;
			int t;
			t = int'(trk);
			if (t >= TRACKS_N) begin
				r.level = '0;
				r.stage = ST_IDLE;
				expected_q.push_back(r);
				return;
			end
			case (c)
				CMD_TICK: advance(t);
				CMD_NOTE_ON: begin
					trk_note[t] = n;
					trk_held[t] = 1'b1;
					if (retrig_zero)
						trk_level[t] = '0;
					trk_wait[t]  = delay_len;
					trk_stage[t] = (delay_len != '0) ? ST_DELAY : ST_ATTACK;
				end
				CMD_NOTE_OFF: begin
					if (trk_held[t] && trk_note[t] == n) begin
						trk_held[t]  = 1'b0;
						trk_stage[t] = ST_RELEASE;
					end
				end
				default: begin
					trk_held[t]  = 1'b0;
					trk_note[t]  = REF_NOTE;
					trk_level[t] = '0;
					trk_wait[t]  = '0;
					trk_stage[t] = ST_IDLE;
				end
			endcase
			r.level = trk_level[t];
			r.stage = trk_stage[t];
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_result(logic [LVL_W-1:0] lvl, logic [STG_W-1:0] stg);
			env_result_t r;
			checked++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", checked));
				return;
			end
			r = expected_q.pop_front();
			if (lvl !== r.level)
				report($sformatf("result %0d: level %0d, expected %0d", checked, lvl, r.level));
			if (stg !== r.stage)
				report($sformatf("result %0d: stage %0d, expected %0d", checked, stg, r.stage));
		endtask
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx  = '0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    cmd       = '0;
	logic [TRK_W-1:0]    track     = '0;
	logic [NOTE_W-1:0]   note      = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [LVL_W-1:0]    level;
	logic [STG_W-1:0]    stage;

	envelope_scoreboard sb;
	logic [CFG_W-1:0]   reg_val [REG_COUNT];
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_req     = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int sent_cnt     = 0;
	int phase_items  = 0;
	int settings_cnt = 0;
	int cycle_cnt    = 0;

	delayed_adsr_envelope_top #(
		.TRACKS(TRACKS_N)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.track(track),
		.note(note),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level(level),
		.stage(stage)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_input(cmd_t'(cmd), track, note);
		if (out_valid && out_ready)
			sb.check_result(level, stage);
	end

	task automatic send(cmd_t c, logic [TRK_W-1:0] t, logic [NOTE_W-1:0] n);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			cmd      <= CMD_W'($urandom_range(3));
			track    <= TRK_W'($urandom_range(15));
			note     <= NOTE_W'($urandom_range(127));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		track    <= t;
		note     <= n;
		do
			@(posedge clk);
		while (!in_ready);
		sent_cnt++;
		phase_items++;
	endtask

	// now and then a stray transaction on any track ahead of the intended one
	task automatic offer(cmd_t c, logic [TRK_W-1:0] t, logic [NOTE_W-1:0] n);
		if ($urandom_range(99) < 15)
			send(cmd_t'($urandom_range(3)), TRK_W'($urandom_range(15)),
				NOTE_W'($urandom_range(127)));
		send(c, t, n);
	endtask

	task automatic play_note();
		logic [TRK_W-1:0]  t;
		logic [NOTE_W-1:0] n, off_n;
		int hold_len, tail_len;
		t        = TRK_W'($urandom_range(TRACKS_N - 1));
		n        = NOTE_W'($urandom_range(127));
		off_n    = ($urandom_range(99) < 85) ? n : NOTE_W'($urandom_range(127));
		hold_len = $urandom_range(30);
		tail_len = $urandom_range(20);
		offer(CMD_NOTE_ON, t, n);
		repeat (hold_len) offer(CMD_TICK, t, NOTE_W'($urandom_range(127)));
		offer(CMD_NOTE_OFF, t, off_n);
		repeat (tail_len) offer(CMD_TICK, t, NOTE_W'($urandom_range(127)));
		if ($urandom_range(99) < 10)
			offer(CMD_ALL_OFF, t, NOTE_W'($urandom_range(127)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.checked < sent_cnt)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_regs(logic [CFG_W-1:0] atk, logic [CFG_W-1:0] dec,
			logic [CFG_W-1:0] rel, logic [CFG_W-1:0] sus, logic [DLY_W-1:0] dly, logic rz);
		cfg_idx_t idx;
		reg_val[CFG_ATTACK_STEP]  = atk;
		reg_val[CFG_DECAY_STEP]   = dec;
		reg_val[CFG_RELEASE_STEP] = rel;
		reg_val[CFG_SUSTAIN]      = sus;
		reg_val[CFG_DELAY]        = CFG_W'(dly);
		reg_val[CFG_RETRIG_ZERO]  = CFG_W'(rz);
		wait_drained();
		idx = idx.first();
		do begin
			cfg_we    <= 1'b1;
			cfg_idx   <= idx;
			cfg_wdata <= reg_val[idx];
			@(posedge clk);
			sb.set_reg(idx, reg_val[idx]);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_we <= 1'b0;
		settings_cnt++;
	endtask

	function automatic logic [CFG_W-1:0] mid_step();
		return CFG_W'($urandom_range(1 << 22, 1 << 20));
	endfunction

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				tx_idle_pct  = 82;
				rx_stall_pct <= 0;
			end
			IDLE_RECEIVER: begin
				tx_idle_pct  = 0;
				rx_stall_pct <= 82;
			end
			IDLE_BOTH: begin
				tx_idle_pct  = 30;
				rx_stall_pct <= 30;
			end
			default: begin
				tx_idle_pct  = 0;
				rx_stall_pct <= 0;
			end
		endcase
	endtask

	initial begin
		bit held_off, paused;
		held_off = 1'b0;
		paused   = 1'b0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle tick, unmatched note off, slow attack and release
		send(CMD_TICK, 4'd0, 7'd0);
		send(CMD_NOTE_OFF, 4'd0, REF_NOTE);
		send(CMD_NOTE_ON, 4'd0, REF_NOTE);
		send(CMD_TICK, 4'd0, 7'd0);
		send(CMD_TICK, 4'd0, 7'd127);
		send(CMD_NOTE_OFF, 4'd0, 7'd61);
		send(CMD_NOTE_OFF, 4'd0, REF_NOTE);
		send(CMD_TICK, 4'd0, 7'd0);
		send(CMD_ALL_OFF, 4'd0, 7'd0);
		send(CMD_NOTE_ON, 4'd15, 7'd127);
		send(CMD_TICK, 4'd15, 7'd0);
		send(CMD_NOTE_OFF, 4'd15, 7'd127);

		// oversized steps, sustain above one, one-sample delay, no retrigger clear
		program_regs(STEP_MAX, STEP_MAX, STEP_MAX, STEP_MAX, 18'd1, 1'b0);
		send(CMD_NOTE_ON, 4'd3, 7'd0);
		send(CMD_TICK, 4'd3, 7'd0);
		send(CMD_TICK, 4'd3, 7'd0);
		send(CMD_TICK, 4'd3, 7'd0);
		send(CMD_TICK, 4'd3, 7'd0);
		send(CMD_NOTE_ON, 4'd3, 7'd5);
		send(CMD_NOTE_OFF, 4'd3, 7'd5);
		send(CMD_TICK, 4'd3, 7'd0);
		send(CMD_TICK, 4'd3, 7'd0);

		// zero steps hold the level
		program_regs('0, '0, '0, '0, '0, 1'b1);
		send(CMD_NOTE_ON, 4'd7, 7'd64);
		send(CMD_TICK, 4'd7, 7'd0);
		send(CMD_ALL_OFF, 4'd7, 7'd0);
		send(CMD_TICK, 4'd7, 7'd0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: program_regs(mid_step(), mid_step(), mid_step(),
					CFG_W'($urandom_range(ONE_Q24)), '0, 1'b1);
				1: program_regs(STEP_MAX, STEP_MAX, STEP_MAX, STEP_MAX, '0, 1'b0);
				2: program_regs(CFG_W'(1), CFG_W'(1), CFG_W'(1), ONE_Q24, DLY_MAX, 1'b1);
				3: program_regs(ONE_Q24, '0, mid_step(), CFG_W'($urandom),
					DLY_W'($urandom_range(4)), 1'b0);
				4: program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
					CFG_W'($urandom), DLY_W'($urandom_range(6)), 1'($urandom));
				5: program_regs(mid_step(), mid_step(), mid_step(),
					CFG_W'($urandom_range(ONE_Q24)), DLY_W'($urandom_range(20, 1)),
					1'($urandom));
				6: program_regs('0, mid_step(), '0, CFG_W'($urandom_range(ONE_Q24)),
					'0, 1'b1);
				default: program_regs(mid_step(), mid_step(), mid_step(),
					CFG_W'($urandom_range(STEP_MAX, ONE_Q24 + 1)), DLY_W'(2), 1'b0);
			endcase
			set_idling(idle_mode_t'(p % 4));
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				play_note();
				if (p == 0 && !held_off && phase_items >= 60) begin
					// result side holds off while transactions keep coming
					hold_req <= hold_req + 1;
					held_off = 1'b1;
				end
				if (p == 5 && !paused && phase_items >= 100) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end

		wait_drained();
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
		$display("%0d transactions under %0d register settings, %0d results checked",
			sent_cnt, settings_cnt, sb.checked);
		$display("idling modes: none, sender, receiver, both; one long result hold-off");
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
